FILE: rtl/wcpb_pkg.sv
`default_nettype none

package wcpb_pkg;

  // Sizing of the sample path and of the column and channel counters.
  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_COLUMNS  = 4096;
  localparam int MAX_CHANNELS = 16;

  localparam int FRAME_W    = 32;
  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int CCOUNT_W   = COL_W + 1;
  localparam int CHAN_W     = $clog2(MAX_CHANNELS);
  localparam int CTOT_W     = CHAN_W + 1;
  localparam int ORIGIN_W   = 16;
  localparam int CWIDTH_W   = 12;
  localparam int HEIGHT_W   = 12;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Boundary numerator (column+1)*frames and its quotient.
  localparam int NUM_W     = FRAME_W + CCOUNT_W;
  localparam int BOUND_W   = FRAME_W + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  // Bar geometry.
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int SHIFT  = SAMPLE_BITS - 4;
  localparam int PIX_W  = 16;
  localparam int LEFT_W = 25;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [DIFF_W-1:0] SAMPLE_ONE = {2'b01, {(SAMPLE_BITS-1){1'b0}}};

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT    = 3'd0,
    REG_COLUMN_COUNT   = 3'd1,
    REG_CHANNEL_SELECT = 3'd2,
    REG_CHANNEL_TOTAL  = 3'd3,
    REG_LEFT_ORIGIN    = 3'd4,
    REG_COLUMN_WIDTH   = 3'd5,
    REG_AREA_HEIGHT    = 3'd6
  } reg_idx_e;

  // Boundary reload sequencer.
  typedef enum logic [2:0] {
    RL_IDLE,
    RL_RATE_START,
    RL_RATE_WAIT,
    RL_BOUND_START,
    RL_BOUND_WAIT
  } reload_state_e;

  // Effective configuration after saturation and clamping.
  typedef struct packed {
    logic [FRAME_W-1:0]  frames;
    logic [CCOUNT_W-1:0] columns;
    logic [CTOT_W-1:0]   channels;
    logic [CHAN_W-1:0]   chan_sel;
    logic [ORIGIN_W-1:0] left_origin;
    logic [CWIDTH_W-1:0] column_width;
    logic [HEIGHT_W-1:0] area_height;
  } cfg_t;

  // Frames per column as quotient and remainder.
  typedef struct packed {
    logic [FRAME_W-1:0] quo;
    logic [COL_W-1:0]   rem;
  } rate_t;

  // Reloaded window boundary.
  typedef struct packed {
    logic               load;
    logic [BOUND_W-1:0] quo;
    logic [COL_W-1:0]   rem;
  } bound_load_t;

  // Datapath state seen by the reload sequencer.
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [COL_W-1:0] boundary_rem;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/wcpb_cfg.sv
`default_nettype none

module wcpb_cfg (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [wcpb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [wcpb_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output wcpb_pkg::cfg_t                    cfg_o,
  output logic                              written_o
);
  import wcpb_pkg::*;

  logic [FRAME_W-1:0]  frame_count_q;
  logic [CCOUNT_W-1:0] column_count_q;
  logic [CHAN_W-1:0]   channel_select_q;
  logic [CTOT_W-1:0]   channel_total_q;
  logic [ORIGIN_W-1:0] left_origin_q;
  logic [CWIDTH_W-1:0] column_width_q;
  logic [HEIGHT_W-1:0] area_height_q;

  logic [FRAME_W-1:0]  frames_eff;
  logic [CCOUNT_W-1:0] cols_sat;
  logic [CCOUNT_W-1:0] cols_eff;
  logic [CTOT_W-1:0]   total_eff;
  logic [CTOT_W-1:0]   total_m1;
  logic [CHAN_W-1:0]   sel_eff;

  // Register file, written one register per transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q    <= FRAME_W'(1);
      column_count_q   <= CCOUNT_W'(1);
      channel_select_q <= '0;
      channel_total_q  <= CTOT_W'(1);
      left_origin_q    <= '0;
      column_width_q   <= CWIDTH_W'(16);
      area_height_q    <= HEIGHT_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_COUNT:    frame_count_q    <= cfg_wdata_i[FRAME_W-1:0];
        REG_COLUMN_COUNT:   column_count_q   <= cfg_wdata_i[CCOUNT_W-1:0];
        REG_CHANNEL_SELECT: channel_select_q <= cfg_wdata_i[CHAN_W-1:0];
        REG_CHANNEL_TOTAL:  channel_total_q  <= cfg_wdata_i[CTOT_W-1:0];
        REG_LEFT_ORIGIN:    left_origin_q    <= cfg_wdata_i[ORIGIN_W-1:0];
        REG_COLUMN_WIDTH:   column_width_q   <= cfg_wdata_i[CWIDTH_W-1:0];
        REG_AREA_HEIGHT:    area_height_q    <= cfg_wdata_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Only writes to existing registers restart the boundary reload.
  assign written_o = cfg_we_i && (cfg_idx_i <= REG_AREA_HEIGHT);

  // Saturate counts; a column count above the frame count is cut to it.
  always_comb begin
    frames_eff = (frame_count_q == '0) ? FRAME_W'(1) : frame_count_q;

    if (column_count_q == '0) begin
      cols_sat = CCOUNT_W'(1);
    end else if (column_count_q > CCOUNT_W'(MAX_COLUMNS)) begin
      cols_sat = CCOUNT_W'(MAX_COLUMNS);
    end else begin
      cols_sat = column_count_q;
    end

    if (FRAME_W'(cols_sat) > frames_eff) begin
      cols_eff = frames_eff[CCOUNT_W-1:0];
    end else begin
      cols_eff = cols_sat;
    end

    if (channel_total_q == '0) begin
      total_eff = CTOT_W'(1);
    end else if (channel_total_q > CTOT_W'(MAX_CHANNELS)) begin
      total_eff = CTOT_W'(MAX_CHANNELS);
    end else begin
      total_eff = channel_total_q;
    end

    // A channel that is not present falls back to the last one.
    total_m1 = total_eff - CTOT_W'(1);
    if (CTOT_W'(channel_select_q) < total_eff) begin
      sel_eff = channel_select_q;
    end else begin
      sel_eff = total_m1[CHAN_W-1:0];
    end
  end

  assign cfg_o.frames       = frames_eff;
  assign cfg_o.columns      = cols_eff;
  assign cfg_o.channels     = total_eff;
  assign cfg_o.chan_sel     = sel_eff;
  assign cfg_o.left_origin  = left_origin_q;
  assign cfg_o.column_width = column_width_q;
  assign cfg_o.area_height  = area_height_q;

endmodule

`default_nettype wire

FILE: rtl/wcpb_div.sv
`default_nettype none

module wcpb_div (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  input  wire  [wcpb_pkg::NUM_W-1:0]        dividend_i,
  input  wire  [wcpb_pkg::CCOUNT_W-1:0]     divisor_i,
  output logic                              done_o,
  output logic [wcpb_pkg::NUM_W-1:0]        quotient_o,
  output logic [wcpb_pkg::CCOUNT_W-1:0]     remainder_o
);
  import wcpb_pkg::*;

  logic [NUM_W-1:0]     work_q;
  logic [CCOUNT_W-1:0]  rem_q;
  logic [CCOUNT_W-1:0]  dvsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;

  logic [CCOUNT_W:0]    trial;
  logic [CCOUNT_W:0]    diff;
  logic                 ge;
  logic [CCOUNT_W-1:0]  rem_next;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    trial    = {rem_q, work_q[NUM_W-1]};
    diff     = trial - {1'b0, dvsr_q};
    ge       = (trial >= {1'b0, dvsr_q});
    rem_next = ge ? diff[CCOUNT_W-1:0] : trial[CCOUNT_W-1:0];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DIV_CNT_W'(NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - DIV_CNT_W'(1);
      done_q <= (cnt_q == DIV_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Quotient bits shift in as dividend bits shift out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      work_q <= {work_q[NUM_W-2:0], ge};
      rem_q  <= rem_next;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

FILE: rtl/wcpb_reload.sv
`default_nettype none

module wcpb_reload (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               written_i,
  input  wire wcpb_pkg::cfg_t               cfg_i,
  input  wire wcpb_pkg::dp_status_t         status_i,
  output logic                              busy_o,
  output wcpb_pkg::rate_t                   rate_o,
  output wcpb_pkg::bound_load_t             bound_o
);
  import wcpb_pkg::*;

  reload_state_e state_q;
  reload_state_e state_d;

  logic [NUM_W-1:0]    num_q;
  rate_t               rate_q;

  logic                div_start;
  logic [NUM_W-1:0]    div_dividend;
  logic                div_done;
  logic [NUM_W-1:0]    div_quo;
  logic [CCOUNT_W-1:0] div_rem;
  logic                rate_capture;
  logic                bound_load;
  logic [CCOUNT_W-1:0] col_plus1;
  logic [NUM_W-1:0]    num_prod;

  // Shared serial divider, first for frames/columns, then for the boundary.
  wcpb_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (cfg_i.columns),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Next state; any register write restarts the sequence.
  always_comb begin
    state_d = state_q;
    case (state_q)
      RL_IDLE:        state_d = RL_IDLE;
      RL_RATE_START:  state_d = RL_RATE_WAIT;
      RL_RATE_WAIT:   if (div_done) state_d = RL_BOUND_START;
      RL_BOUND_START: state_d = RL_BOUND_WAIT;
      RL_BOUND_WAIT:  if (div_done) state_d = RL_IDLE;
      default:        state_d = RL_IDLE;
    endcase
    if (written_i) begin
      state_d = RL_RATE_START;
    end
  end

  // Sequencer outputs.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = NUM_W'(cfg_i.frames);
    rate_capture = 1'b0;
    bound_load   = 1'b0;
    case (state_q)
      RL_IDLE: ;
      RL_RATE_START: begin
        div_start = 1'b1;
      end
      RL_RATE_WAIT: begin
        rate_capture = div_done;
      end
      RL_BOUND_START: begin
        div_start    = 1'b1;
        div_dividend = num_q;
      end
      RL_BOUND_WAIT: begin
        bound_load = div_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Boundary numerator (column+1)*frames, taken as the first division starts.
  assign col_plus1 = {1'b0, status_i.column} + CCOUNT_W'(1);
  assign num_prod  = col_plus1 * cfg_i.frames;

  always_ff @(posedge clk_i) begin
    if (state_q == RL_RATE_START) begin
      num_q <= num_prod;
    end
  end

  // Frames per column; reset matches one frame in one column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q.quo <= FRAME_W'(1);
      rate_q.rem <= '0;
    end else if (rate_capture) begin
      rate_q.quo <= div_quo[FRAME_W-1:0];
      rate_q.rem <= div_rem[COL_W-1:0];
    end
  end

  // A boundary beyond any reachable frame saturates; it can never close.
  always_comb begin
    bound_o.load = bound_load;
    bound_o.rem  = div_rem[COL_W-1:0];
    if (|div_quo[NUM_W-1:BOUND_W]) begin
      bound_o.quo = '1;
    end else begin
      bound_o.quo = div_quo[BOUND_W-1:0];
    end
  end

  assign rate_o = rate_q;
  assign busy_o = (state_q != RL_IDLE);

endmodule

`default_nettype wire

FILE: rtl/wcpb_datapath.sv
`default_nettype none

module wcpb_datapath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire wcpb_pkg::cfg_t               cfg_i,
  input  wire wcpb_pkg::rate_t              rate_i,
  input  wire wcpb_pkg::bound_load_t        bound_i,
  input  wire                               hold_i,
  input  wire                               sample_valid_i,
  output logic                              sample_stall_o,
  input  wire wcpb_pkg::sample_t            sample_i,
  output logic                              bar_valid_o,
  input  wire                               bar_stall_i,
  output logic [wcpb_pkg::COL_W-1:0]        column_index_o,
  output logic [wcpb_pkg::LEFT_W-1:0]       bar_left_o,
  output logic [wcpb_pkg::PIX_W-1:0]        bar_top_o,
  output logic [wcpb_pkg::PIX_W-1:0]        bar_height_o,
  output logic                              last_column_o,
  output wcpb_pkg::dp_status_t              status_o
);
  import wcpb_pkg::*;

  // Pipeline registers.
  logic                in_vld_q;
  sample_t             sample_q;
  logic                em_vld_q;
  logic [COL_W-1:0]    em_cp_q;
  sample_t             em_min_q;
  sample_t             em_max_q;
  logic                em_last_q;
  logic                out_vld_q;
  logic [COL_W-1:0]    out_col_q;
  logic [LEFT_W-1:0]   out_left_q;
  logic [PIX_W-1:0]    out_top_q;
  logic [PIX_W-1:0]    out_height_q;
  logic                out_last_q;

  // Pass state.
  logic [CHAN_W-1:0]   chan_pos_q;
  logic [FRAME_W-1:0]  fp_q;
  logic [COL_W-1:0]    cp_q;
  logic [BOUND_W-1:0]  bq_q;
  logic [COL_W-1:0]    br_q;
  sample_t             min_q;
  sample_t             max_q;

  logic                out_ready;
  logic                em_ready;
  logic                in_ready;
  logic                b_fire;
  logic                in_accept;

  logic [CTOT_W-1:0]   pos_inc;
  logic [CHAN_W-1:0]   chan_pos_next;
  logic                measured;
  sample_t             new_min;
  sample_t             new_max;
  logic [BOUND_W-1:0]  frame_inc;
  logic                hit;
  logic                emit;
  logic [CCOUNT_W-1:0] col_inc;
  logic                last;
  logic [COL_W:0]      br_sum;
  logic [COL_W:0]      br_wrap;
  logic                wrap;
  logic [COL_W-1:0]    br_next;
  logic [BOUND_W-1:0]  bq_next;

  logic [DIFF_W-1:0]            span_ext;
  logic [SAMPLE_BITS-1:0]       span;
  logic [DIFF_W-1:0]            headroom;
  logic [SAMPLE_BITS+HEIGHT_W-1:0] span_prod;
  logic [DIFF_W+HEIGHT_W-1:0]   top_prod;
  logic [PIX_W-1:0]             height_raw;
  logic [PIX_W-1:0]             height_val;
  logic [CWIDTH_W+COL_W-1:0]    left_prod;
  logic [LEFT_W-1:0]            left_val;

  // Handshake: each stage loads when empty or when its content moves on.
  assign out_ready      = !out_vld_q || !bar_stall_i;
  assign em_ready       = !em_vld_q || out_ready;
  assign b_fire         = in_vld_q && em_ready;
  assign in_ready       = !in_vld_q || em_ready;
  assign sample_stall_o = hold_i || !in_ready;
  assign in_accept      = sample_valid_i && !sample_stall_o;

  // Per-sample update: channel slot, extremes and window boundary test.
  always_comb begin
    pos_inc       = {1'b0, chan_pos_q} + CTOT_W'(1);
    chan_pos_next = (pos_inc >= cfg_i.channels) ? '0 : pos_inc[CHAN_W-1:0];
    measured      = (chan_pos_q == cfg_i.chan_sel);
    new_min       = (sample_q < min_q) ? sample_q : min_q;
    new_max       = (sample_q > max_q) ? sample_q : max_q;
    frame_inc     = {1'b0, fp_q} + BOUND_W'(1);
    hit           = (frame_inc >= bq_q);
    emit          = measured && hit;
    col_inc       = {1'b0, cp_q} + CCOUNT_W'(1);
    last          = (col_inc >= cfg_i.columns);
    // Next boundary: add frames/columns with a carry out of the remainder.
    br_sum        = {1'b0, br_q} + {1'b0, rate_i.rem};
    wrap          = (br_sum >= cfg_i.columns);
    br_wrap       = br_sum - cfg_i.columns;
    br_next       = wrap ? br_wrap[COL_W-1:0] : br_sum[COL_W-1:0];
    bq_next       = bq_q + BOUND_W'(rate_i.quo) + BOUND_W'(wrap);
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
    end
  end

  // Pass state; a reload from the sequencer replaces the boundary.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_pos_q <= '0;
      fp_q       <= '0;
      cp_q       <= '0;
      bq_q       <= BOUND_W'(1);
      br_q       <= '0;
      min_q      <= SAMPLE_MAX;
      max_q      <= SAMPLE_MIN;
    end else if (bound_i.load) begin
      bq_q <= bound_i.quo;
      br_q <= bound_i.rem;
    end else if (b_fire) begin
      chan_pos_q <= chan_pos_next;
      if (measured) begin
        if (!hit) begin
          fp_q  <= frame_inc[FRAME_W-1:0];
          min_q <= new_min;
          max_q <= new_max;
        end else if (last) begin
          // End of pass: the frame, column and boundary counters restart.
          fp_q  <= '0;
          cp_q  <= '0;
          bq_q  <= BOUND_W'(rate_i.quo);
          br_q  <= rate_i.rem;
          min_q <= SAMPLE_MAX;
          max_q <= SAMPLE_MIN;
        end else begin
          // The closing sample also opens the next window.
          fp_q  <= frame_inc[FRAME_W-1:0];
          cp_q  <= col_inc[COL_W-1:0];
          bq_q  <= bq_next;
          br_q  <= br_next;
          min_q <= sample_q;
          max_q <= sample_q;
        end
      end
    end
  end

  // Window summary register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_vld_q <= 1'b0;
    end else if (em_ready) begin
      em_vld_q <= b_fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && emit) begin
      em_cp_q   <= cp_q;
      em_min_q  <= new_min;
      em_max_q  <= new_max;
      em_last_q <= last;
    end
  end

  // Bar geometry from the window extremes.
  always_comb begin
    span_ext   = DIFF_W'(em_max_q) - DIFF_W'(em_min_q);
    span       = span_ext[SAMPLE_BITS-1:0];
    headroom   = SAMPLE_ONE - DIFF_W'(em_max_q);
    span_prod  = span * cfg_i.area_height;
    top_prod   = headroom * cfg_i.area_height;
    height_raw = span_prod[SHIFT +: PIX_W];
    height_val = (height_raw < PIX_W'(cfg_i.column_width)) ?
                 PIX_W'(cfg_i.column_width) : height_raw;
    left_prod  = cfg_i.column_width * em_cp_q;
    left_val   = LEFT_W'(cfg_i.left_origin) + LEFT_W'(left_prod);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ready) begin
      out_vld_q <= em_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && em_vld_q) begin
      out_col_q    <= em_cp_q;
      out_left_q   <= left_val;
      out_top_q    <= top_prod[SHIFT +: PIX_W];
      out_height_q <= height_val;
      out_last_q   <= em_last_q;
    end
  end

  assign bar_valid_o    = out_vld_q;
  assign column_index_o = out_col_q;
  assign bar_left_o     = out_left_q;
  assign bar_top_o      = out_top_q;
  assign bar_height_o   = out_height_q;
  assign last_column_o  = out_last_q;

  assign status_o.column       = cp_q;
  assign status_o.boundary_rem = br_q;

endmodule

`default_nettype wire

FILE: rtl/waveform_column_peak_bars.sv
// A window's closing sample enters the input register, its bar then the summary and output
// registers. Throughput: one sample per cycle unless writes, reloads or bar stalls hold it;
// the output register lets intake go on while a bar waits. A register write starts a
// boundary reload of two 45-step serial divisions on the shared divider, stalling samples.
// Reset (asynchronous, active low) restores the register defaults and starts a new pass
// without a reload.
`default_nettype none

module waveform_column_peak_bars (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [wcpb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [wcpb_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire                               sample_valid_i,
  output logic                              sample_stall_o,
  input  wire wcpb_pkg::sample_t            sample_i,
  output logic                              bar_valid_o,
  input  wire                               bar_stall_i,
  output logic [wcpb_pkg::COL_W-1:0]        column_index_o,
  output logic [wcpb_pkg::LEFT_W-1:0]       bar_left_o,
  output logic [wcpb_pkg::PIX_W-1:0]        bar_top_o,
  output logic [wcpb_pkg::PIX_W-1:0]        bar_height_o,
  output logic                              last_column_o
);
  import wcpb_pkg::*;

  cfg_t        cfg;
  logic        written;
  logic        reload_busy;
  rate_t       rate;
  bound_load_t bound;
  dp_status_t  status;
  logic        hold;

  // Configuration registers and their effective values.
  wcpb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .written_o   (written)
  );

  // Boundary reload after a register write.
  wcpb_reload u_reload (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .written_i (written),
    .cfg_i     (cfg),
    .status_i  (status),
    .busy_o    (reload_busy),
    .rate_o    (rate),
    .bound_o   (bound)
  );

  // Samples wait while registers change or a reload runs.
  assign hold = reload_busy || cfg_we_i;

  wcpb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .rate_i         (rate),
    .bound_i        (bound),
    .hold_i         (hold),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_i       (sample_i),
    .bar_valid_o    (bar_valid_o),
    .bar_stall_i    (bar_stall_i),
    .column_index_o (column_index_o),
    .bar_left_o     (bar_left_o),
    .bar_top_o      (bar_top_o),
    .bar_height_o   (bar_height_o),
    .last_column_o  (last_column_o),
    .status_o       (status)
  );

  // No sample transfer may land while the boundary is being recomputed.
  a_no_transfer_in_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_valid_i && !sample_stall_o) |-> !reload_busy)
    else $error("sample transfer during boundary reload");

  // Outside a reload the boundary remainder stays below the column count.
  a_rem_below_columns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !reload_busy |-> ({1'b0, status.boundary_rem} < cfg.columns))
    else $error("boundary remainder out of range");

  // Loading the boundary ends the reload unless another write arrives.
  a_reload_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bound.load && !written) |=> !reload_busy)
    else $error("reload did not finish after boundary load");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import wcpb_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int IDLE_MAX      = 17;
  // A bar passes the summary and output registers after its closing sample; leave a margin on top.
  localparam int SETTLE_CYCLES = 8;
  // A reload and an idle draw, capped at IDLE_MAX, both end well within this limit.
  localparam int QUIET_LIMIT   = 1000;
  localparam int ITEM_TARGET   = 550;
  localparam int BAR_TARGET    = 48;
  localparam int SETTING_CAP   = 200;

  // One bar as it appears on the output channel.
  typedef struct {
    logic [COL_W-1:0]  column;
    logic [LEFT_W-1:0] left;
    logic [PIX_W-1:0]  top;
    logic [PIX_W-1:0]  height;
    logic              last;
  } bar_t;

  // Tracks the window state of the block and holds the bars still owed by it.
  class bar_tracker;
    logic [FRAME_W-1:0]  frame_count;
    logic [CCOUNT_W-1:0] column_count;
    logic [CHAN_W-1:0]   channel_select;
    logic [CTOT_W-1:0]   channel_total;
    logic [ORIGIN_W-1:0] left_origin;
    logic [CWIDTH_W-1:0] column_width;
    logic [HEIGHT_W-1:0] area_height;

    logic [CHAN_W-1:0]   slot;
    longint unsigned     frames_seen;
    logic [COL_W-1:0]    column;
    longint unsigned     boundary_num;
    int                  lowest;
    int                  highest;

    bar_t pending_bars[$];
    int   errors;
    int   bars_checked;
    int   bars_predicted;

    function new();
      frame_count    = 1;
      column_count   = 1;
      channel_select = 0;
      channel_total  = 1;
      left_origin    = 0;
      column_width   = 16;
      area_height    = 256;
      slot           = 0;
      errors         = 0;
      bars_checked   = 0;
      bars_predicted = 0;
      restart_pass();
    endfunction

    // A zero frame count counts as one frame.
    function longint unsigned frames();
      longint unsigned f;
      f = frame_count;
      return (f == 0) ? 1 : f;
    endfunction

    // Column count saturated to the supported range, then limited by the frame count.
    function longint unsigned columns();
      longint unsigned c;
      c = column_count;
      if (c < 1) c = 1;
      if (c > MAX_COLUMNS) c = MAX_COLUMNS;
      if (c > frames()) c = frames();
      return c;
    endfunction

    function int channels();
      int t;
      t = channel_total;
      if (t < 1) t = 1;
      if (t > MAX_CHANNELS) t = MAX_CHANNELS;
      return t;
    endfunction

    function void restart_pass();
      frames_seen  = 0;
      column       = 0;
      boundary_num = frames();
      lowest       = int'(SAMPLE_MAX);
      highest      = int'(SAMPLE_MIN);
    endfunction

    // A register write takes effect at once and reloads the window boundary.
    function void write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      longint unsigned col;
      case (idx)
        REG_FRAME_COUNT:    frame_count    = value[FRAME_W-1:0];
        REG_COLUMN_COUNT:   column_count   = value[CCOUNT_W-1:0];
        REG_CHANNEL_SELECT: channel_select = value[CHAN_W-1:0];
        REG_CHANNEL_TOTAL:  channel_total  = value[CTOT_W-1:0];
        REG_LEFT_ORIGIN:    left_origin    = value[ORIGIN_W-1:0];
        REG_COLUMN_WIDTH:   column_width   = value[CWIDTH_W-1:0];
        REG_AREA_HEIGHT:    area_height    = value[HEIGHT_W-1:0];
        default:            return;
      endcase
      col = column;
      boundary_num = (col + 1) * frames();
    endfunction

    // Notes an accepted sample and queues the bar it closes, if any.
    function bit take_sample(sample_t s);
      int              total;
      int              pick;
      int              pos;
      int              level;
      int              headroom;
      longint unsigned span;
      longint unsigned tall;
      longint unsigned rise;
      longint unsigned col;
      bar_t            b;
      total = channels();
      pick  = (int'(channel_select) < total) ? int'(channel_select) : total - 1;
      pos   = slot;
      slot  = (pos + 1 >= total) ? '0 : CHAN_W'(pos + 1);
      if (pos != pick) return 1'b0;

      level = int'(s);
      if (level < lowest) lowest = level;
      if (level > highest) highest = level;
      if (frames_seen + 1 < boundary_num / columns()) begin
        frames_seen++;
        return 1'b0;
      end

      // Window closed: build the bar from its extremes.
      span = highest - lowest;
      tall = (span * area_height) >> SHIFT;
      if (tall < column_width) tall = column_width;
      headroom = int'(SAMPLE_ONE) - highest;
      rise = headroom;
      rise = (rise * area_height) >> SHIFT;
      col = column;
      b.column = column;
      b.left   = LEFT_W'(left_origin + column_width * col);
      b.top    = PIX_W'(rise);
      b.height = PIX_W'(tall);
      b.last   = (col + 1 >= columns());
      pending_bars.push_back(b);
      bars_predicted++;

      // The next window shares the closing sample.
      if (b.last) begin
        restart_pass();
      end else begin
        column++;
        col = column;
        boundary_num = (col + 1) * frames();
        lowest = level;
        highest = level;
        frames_seen++;
      end
      return 1'b1;
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compares a transferred bar with the oldest one owed.
    function void check_bar(bar_t got);
      bar_t want;
      if (pending_bars.size() == 0) begin
        $display("%0t: bar for column %0d arrived with none owed", $time, got.column);
        errors++;
        return;
      end
      want = pending_bars.pop_front();
      bars_checked++;
      check_field("column_index", want.column, got.column);
      check_field("bar_left", want.left, got.left);
      check_field("bar_top", want.top, got.top);
      check_field("bar_height", want.height, got.height);
      check_field("last_column", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i        = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  sample_valid = 1'b0;
  sample_t               sample_data  = '0;
  logic                  bar_stall    = 1'b0;

  wire                   sample_stall;
  wire                   bar_valid;
  wire [COL_W-1:0]       column_index;
  wire [LEFT_W-1:0]      bar_left;
  wire [PIX_W-1:0]       bar_top;
  wire [PIX_W-1:0]       bar_height;
  wire                   last_column;

  bar_tracker tracker;
  bit         sender_calm   = 1'b0;
  bit         receiver_calm = 1'b0;
  int         samples_sent  = 0;
  int         settings_used = 0;
  int         quiet_cycles  = 0;

  waveform_column_peak_bars u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .sample_valid_i (sample_valid),
    .sample_stall_o (sample_stall),
    .sample_i       (sample_data),
    .bar_valid_o    (bar_valid),
    .bar_stall_i    (bar_stall),
    .column_index_o (column_index),
    .bar_left_o     (bar_left),
    .bar_top_o      (bar_top),
    .bar_height_o   (bar_height),
    .last_column_o  (last_column)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Idle cycles before the next transfer; a calm stretch never idles.
  function int draw_gap(bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, IDLE_MAX);
  endfunction

  // Half full-range noise, some values close to a center, some full scale.
  function sample_t next_sample(sample_t center);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return sample_t'($urandom);
    if (r < 8) return sample_t'(int'(center) + $urandom_range(0, 63) - 32);
    if (r == 8) return SAMPLE_MAX;
    return SAMPLE_MIN;
  endfunction

  // Register values weighted toward short passes, with the extremes mixed in.
  function logic [CFG_DATA_W-1:0] random_value(reg_idx_e idx);
    int r;
    r = $urandom_range(0, 9);
    case (idx)
      REG_FRAME_COUNT:
        return (r == 0) ? 0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? $urandom
             : $urandom_range(1, 40);
      REG_COLUMN_COUNT:
        return (r == 0) ? 0 : (r == 1) ? MAX_COLUMNS
             : (r == 2) ? $urandom_range(MAX_COLUMNS + 1, 8191) : $urandom_range(1, 48);
      REG_CHANNEL_SELECT:
        return $urandom_range(0, 15);
      REG_CHANNEL_TOTAL:
        return (r == 0) ? 0 : (r == 1) ? MAX_CHANNELS
             : (r == 2) ? $urandom_range(MAX_CHANNELS + 1, 31) : $urandom_range(1, 4);
      REG_LEFT_ORIGIN:
        return (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(0, 65535);
      REG_COLUMN_WIDTH, REG_AREA_HEIGHT:
        return (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(1, 4095);
      default:
        return '0;
    endcase
  endfunction

  // One sample transfer, preceded by a random number of idle cycles.
  task automatic send_sample(sample_t value);
    int gap;
    gap = draw_gap(sender_calm);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_valid <= 1'b1;
    sample_data  <= value;
    do @(posedge clk_i); while (sample_stall);
    void'(tracker.take_sample(value));
    samples_sent++;
  endtask

  // Drops valid, waits for every owed bar, then lets the pipeline run dry.
  task automatic drain_bars();
    sample_valid <= 1'b0;
    while (tracker.pending_bars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A register write, then a wait while the boundary reload holds off samples.
  task automatic write_register(reg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    tracker.write_reg(idx, value);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (sample_stall) @(posedge clk_i);
  endtask

  // Output side: stall for a random while, then take the next bar.
  initial begin
    int   hold;
    bar_t got;
    wait (rst_n);
    forever begin
      hold = draw_gap(receiver_calm);
      if (hold > 0) begin
        bar_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      bar_stall <= 1'b0;
      do @(posedge clk_i); while (!bar_valid);
      got.column = column_index;
      got.left   = bar_left;
      got.top    = bar_top;
      got.height = bar_height;
      got.last   = last_column;
      tracker.check_bar(got);
    end
  end

  // Watchdog: any transfer or register write restarts the count.
  always @(posedge clk_i) begin
    if (!rst_n || (sample_valid && !sample_stall) || (bar_valid && !bar_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d bars still owed", $time, quiet_cycles,
               tracker.pending_bars.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_t    center;
    int         count;
    reg_idx_e   idx;
    logic [CFG_DATA_W-1:0] value;
    sample_t    full_scale[8];
    sample_t    shared_run[6];

    full_scale = '{SAMPLE_MAX, SAMPLE_MIN, 16'sh0000, -16'sh0001, 16'sh0001,
                   16'sh5555, -16'sh5556, SAMPLE_MAX};
    shared_run = '{SAMPLE_MAX, SAMPLE_MIN, 16'sh0064, 16'sh0064, -16'sh0001, 16'sh0000};
    tracker = new();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one frame per pass, so every sample closes a bar.
    settings_used++;
    foreach (full_scale[i]) send_sample(full_scale[i]);
    drain_bars();

    // Zero frames, columns, channels, width and height.
    settings_used++;
    for (int r = 0; r <= int'(REG_AREA_HEIGHT); r++) write_register(reg_idx_e'(r), '0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    drain_bars();

    // Two channels with an absent channel selected, so the last one is measured.
    // Full-scale geometry; three windows over six frames share their edge samples.
    settings_used++;
    write_register(REG_FRAME_COUNT, 6);
    write_register(REG_COLUMN_COUNT, 3);
    write_register(REG_CHANNEL_TOTAL, 2);
    write_register(REG_CHANNEL_SELECT, 15);
    write_register(REG_LEFT_ORIGIN, 16'hFFFF);
    write_register(REG_COLUMN_WIDTH, 4095);
    write_register(REG_AREA_HEIGHT, 4095);
    foreach (shared_run[i]) begin
      send_sample(sample_t'($urandom));
      send_sample(shared_run[i]);
    end
    drain_bars();

    // Random settings; passes are left open, so later writes land mid-pass.
    while ((samples_sent < ITEM_TARGET || tracker.bars_predicted < BAR_TARGET) &&
           settings_used < SETTING_CAP) begin
      settings_used++;
      for (int r = 0; r <= int'(REG_AREA_HEIGHT); r++) begin
        if ($urandom_range(0, 1) == 1) begin
          idx = reg_idx_e'(r);
          value = random_value(idx);
          write_register(idx, value);
        end
      end
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      center = sample_t'($urandom);
      count = $urandom_range(8, 40);
      repeat (count) send_sample(next_sample(center));
      drain_bars();
    end

    $display("Sent %0d samples under %0d register settings.", samples_sent, settings_used);
    $display("Compared %0d bars, %0d field mismatches.", tracker.bars_checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
